[design/isl_pkg.sv]
// Shared types and constants for the identifier and symbol lexer.
// Holds token kind codes, character codes and the character class record.
// No dependencies.
package isl_pkg;

  // Token kind codes carried in the kind field of each result.
  localparam int KIND_W = 4;
  localparam logic [KIND_W-1:0] K_FUN      = 4'd0;
  localparam logic [KIND_W-1:0] K_NAME     = 4'd1;
  localparam logic [KIND_W-1:0] K_SPACE    = 4'd2;
  localparam logic [KIND_W-1:0] K_LPAREN   = 4'd3;
  localparam logic [KIND_W-1:0] K_RPAREN   = 4'd4;
  localparam logic [KIND_W-1:0] K_LT       = 4'd5;
  localparam logic [KIND_W-1:0] K_GT       = 4'd6;
  localparam logic [KIND_W-1:0] K_COLON    = 4'd7;
  localparam logic [KIND_W-1:0] K_COMMA    = 4'd8;
  localparam logic [KIND_W-1:0] K_END      = 4'd9;
  localparam logic [KIND_W-1:0] K_BADCHAR  = 4'd10;
  localparam logic [KIND_W-1:0] K_AFTEREND = 4'd11;
  localparam logic [KIND_W-1:0] K_TOOLONG  = 4'd12;

  // Character codes.
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

  // Letters of the function keyword.
  localparam logic [7:0] CH_KEY_F = 8'h66;
  localparam logic [7:0] CH_KEY_U = 8'h75;
  localparam logic [7:0] CH_KEY_N = 8'h6E;

  // Classification of one input character.
  typedef struct packed {
    logic              is_space;
    logic              is_head;
    logic              is_tail;
    logic              is_sym;
    logic [KIND_W-1:0] sym_kind;
  } isl_class_t;

endpackage

[design/identifier_symbol_lexer_unit.sv]
// Identifier and symbol lexer: one character or end mark per input request.
// A quiet request leaves the input ready; a token passes through the ST_TERM state and is loaded
// into the output register once that register is free; ending a word other than the keyword replays
// it from the word buffer, a buffer read (ST_RD) and an emit (ST_NAME) for each character. Requests
// wait while the replay runs. Reset (rst, synchronous) clears the word length, flags and the
// sequencer; the word buffer memory is not cleared and is only read below the word length.
module identifier_symbol_lexer_unit
  import isl_pkg::*;
#(
  parameter int MAX_WORD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] kind, [11:4] name_char, [12] name_last, zero above
  output logic        m_tlast    // last
);

  localparam int LEN_W  = $clog2(MAX_WORD + 1);
  localparam int ADDR_W = $clog2(MAX_WORD);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SPACE   = 3'd1;
  localparam logic [2:0] ST_WORD    = 3'd2;
  localparam logic [2:0] ST_RD      = 3'd3;
  localparam logic [2:0] ST_NAME    = 3'd4;
  localparam logic [2:0] ST_TOOLONG = 3'd5;
  localparam logic [2:0] ST_TERM    = 3'd6;

  // Architectural lexer state.
  logic [LEN_W-1:0]  word_length;
  logic              word_overflowed;
  logic              previous_was_word;
  logic              input_ended;
  logic              fun_ok;

  // Sequencer and the latched copy of the word being flushed.
  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [LEN_W-1:0]  fl_len;
  logic              fl_ovf;
  logic              fl_fun;
  logic              fl_term;
  logic [KIND_W-1:0] term_kind;

  // Output register.
  logic [KIND_W-1:0] out_kind;
  logic [7:0]        out_char;
  logic              out_nlast;
  logic              out_free;

  isl_class_t        cls;
  logic              accept;
  logic              eoi;
  logic              acc_flush;
  logic              acc_term;
  logic [KIND_W-1:0] acc_kind;
  logic              acc_start;
  logic              acc_append;
  logic              len_zero;
  logic              len_full;

  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic [7:0]        e_char;
  logic              e_nlast;
  logic              e_last;
  logic              name_end;

  logic              ram_we;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  isl_class u_class (
    .ch  (s_tdata),
    .cls (cls)
  );

  isl_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD)
  ) u_word_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_length[ADDR_W-1:0]),
    .wdata (s_tdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign eoi      = s_tuser;
  assign len_zero = (word_length == '0);
  assign len_full = (word_length == LEN_W'(MAX_WORD));
  assign out_free = !m_tvalid || m_tready;
  assign name_end = ((LEN_W'(idx) + LEN_W'(1)) == fl_len);

  // Decode of the request being accepted.
  always_comb begin
    acc_flush  = !input_ended && !len_zero && (eoi || !cls.is_tail);
    acc_term   = 1'b0;
    acc_kind   = K_END;
    acc_start  = 1'b0;
    acc_append = 1'b0;
    if (input_ended) begin
      acc_term = 1'b1;
      acc_kind = K_AFTEREND;
    end else if (eoi) begin
      acc_term = 1'b1;
      acc_kind = K_END;
    end else if (acc_flush || len_zero) begin
      if (cls.is_head && len_zero) begin
        acc_start = 1'b1;
      end else if (!cls.is_space && !cls.is_head) begin
        acc_term = 1'b1;
        acc_kind = cls.sym_kind;
      end
    end else begin
      acc_append = 1'b1;
    end
  end

  // Word buffer write: the first character or a continuation that still fits.
  assign ram_we = accept && (acc_start || (acc_append && !len_full));

  // Sequencer: replays the flushed word (space, keyword or name characters, overrun mark) and the terminating token.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    ram_re     = 1'b0;
    emit       = 1'b0;
    e_kind     = K_END;
    e_char     = 8'd0;
    e_nlast    = 1'b0;
    e_last     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (acc_flush) begin
            state_next = previous_was_word ? ST_SPACE : ST_WORD;
          end else if (acc_term) begin
            state_next = ST_TERM;
          end
        end
      end
      ST_SPACE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = K_SPACE;
          state_next = ST_WORD;
        end
      end
      ST_WORD: begin
        if (fl_fun) begin
          if (out_free) begin
            emit       = 1'b1;
            e_kind     = K_FUN;
            e_last     = !fl_term;
            state_next = fl_term ? ST_TERM : ST_IDLE;
          end
        end else begin
          idx_next   = '0;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        ram_re     = 1'b1;
        state_next = ST_NAME;
      end
      ST_NAME: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = K_NAME;
          e_char  = ram_rdata;
          e_nlast = name_end;
          e_last  = name_end && !fl_ovf && !fl_term;
          if (name_end) begin
            if (fl_ovf) begin
              state_next = ST_TOOLONG;
            end else begin
              state_next = fl_term ? ST_TERM : ST_IDLE;
            end
          end else begin
            idx_next   = idx + ADDR_W'(1);
            state_next = ST_RD;
          end
        end
      end
      ST_TOOLONG: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = K_TOOLONG;
          e_last     = !fl_term;
          state_next = fl_term ? ST_TERM : ST_IDLE;
        end
      end
      ST_TERM: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = term_kind;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    idx <= idx_next;
  end

  // Lexer state update; all of it is settled when the request is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length       <= '0;
      word_overflowed   <= 1'b0;
      previous_was_word <= 1'b0;
      input_ended       <= 1'b0;
      fun_ok            <= 1'b0;
    end else if (accept && !input_ended) begin
      if (eoi) begin
        input_ended <= 1'b1;
      end
      if (acc_flush) begin
        word_length       <= '0;
        word_overflowed   <= 1'b0;
        previous_was_word <= 1'b1;
      end
      if (!eoi && cls.is_sym && (acc_flush || len_zero)) begin
        previous_was_word <= 1'b0;
      end
      if (acc_start) begin
        word_length     <= LEN_W'(1);
        word_overflowed <= 1'b0;
        fun_ok          <= (s_tdata == CH_KEY_F);
      end
      if (acc_append) begin
        if (len_full) begin
          word_overflowed <= 1'b1;
        end else begin
          word_length <= word_length + LEN_W'(1);
        end
        if (word_length == LEN_W'(1)) begin
          fun_ok <= fun_ok && (s_tdata == CH_KEY_U);
        end else if (word_length == LEN_W'(2)) begin
          fun_ok <= fun_ok && (s_tdata == CH_KEY_N);
        end
      end
    end
  end

  // Snapshot of the word being flushed and of the terminating token.
  always_ff @(posedge clk) begin
    if (accept) begin
      fl_term   <= acc_term;
      term_kind <= acc_kind;
      if (acc_flush) begin
        fl_len <= word_length;
        fl_ovf <= word_overflowed;
        fl_fun <= (word_length == LEN_W'(3)) && !word_overflowed && fun_ok;
      end
    end
  end

  // Output register: loads a result whenever the slot is free or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      out_kind  <= e_kind;
      out_char  <= e_char;
      out_nlast <= e_nlast;
      m_tlast   <= e_last;
    end
  end

  assign m_tdata = {3'b000, out_nlast, out_char, out_kind};

endmodule

[design/isl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the word buffer. No dependencies.
module isl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/isl_class.sv]
// Character classifier: whitespace, word head, word tail and symbol kind.
// Depends on isl_pkg.
module isl_class
  import isl_pkg::*;
(
  input  logic [7:0]  ch,
  output isl_class_t  cls
);

  logic is_letter;
  logic is_digit;

  // Word characters.
  assign is_letter = (ch inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]});
  assign is_digit  = (ch inside {[CH_DIGIT_0:CH_DIGIT_9]});

  always_comb begin
    cls.is_space = (ch inside {CH_TAB, CH_SPACE});
    cls.is_head  = is_letter || (ch == CH_UNDERSCORE);
    cls.is_tail  = is_letter || is_digit || (ch == CH_UNDERSCORE);
    cls.is_sym   = 1'b1;
    // Symbol decode; anything else is a bad character.
    case (ch)
      CH_LPAREN: cls.sym_kind = K_LPAREN;
      CH_RPAREN: cls.sym_kind = K_RPAREN;
      CH_LT:     cls.sym_kind = K_LT;
      CH_GT:     cls.sym_kind = K_GT;
      CH_COLON:  cls.sym_kind = K_COLON;
      CH_COMMA:  cls.sym_kind = K_COMMA;
      default: begin
        cls.sym_kind = K_BADCHAR;
        cls.is_sym   = 1'b0;
      end
    endcase
  end

endmodule

[sim/identifier_symbol_lexer_unit_tb.sv]
// Self-checking testbench for identifier_symbol_lexer_unit: character and end-mark requests
// in, token results out, each result checked against a built-in lexer predictor.
// Depends on isl_pkg and the lexer top level only.
`timescale 1ns / 100ps

module identifier_symbol_lexer_unit_tb;
  import isl_pkg::*;

  localparam int MAX_WORD     = 32;
  localparam int RANDOM_ITEMS = 200;
  localparam int TAIL_CYCLES  = 2 * MAX_WORD + 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;

  // One input request waiting to be driven.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         drain;
  } char_req_t;

  // One expected token result.
  typedef struct {
    logic [3:0] kind;
    logic [7:0] name_char;
    logic       name_last;
    logic       last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  char_req_t   char_queue[$];
  token_t      expected_tokens[$];
  token_t      step_tokens[$];

  // Predictor state.
  logic [7:0]  word_buf[MAX_WORD];
  int          word_len = 0;
  bit          word_over = 1'b0;
  bit          prev_word = 1'b0;
  bit          text_ended = 1'b0;

  int          total_items = 0;
  int          sent_count = 0;
  int          counted_items = 0;
  bit          drain_next = 1'b0;
  int          tokens_checked = 0;
  int          fun_seen = 0;
  int          toolong_seen = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  identifier_symbol_lexer_unit #(
    .MAX_WORD(MAX_WORD)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Character classes of the token grammar.
  function automatic bit is_word_head(logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           c == CH_UNDERSCORE;
  endfunction

  function automatic bit is_word_tail(logic [7:0] c);
    return is_word_head(c) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
  endfunction

  function automatic token_t make_token(logic [3:0] kind, logic [7:0] chr, logic nlast);
    token_t t;
    t.kind      = kind;
    t.name_char = chr;
    t.name_last = nlast;
    t.last      = 1'b0;
    return t;
  endfunction

  // A finished word: optional space, then either the keyword or its characters, then any overrun mark.
  task flush_word;
    int i;
    if (prev_word)
      step_tokens.insert(step_tokens.size(), make_token(K_SPACE, 8'h00, 1'b0));
    if (word_len == 3 && !word_over && word_buf[0] == CH_KEY_F && word_buf[1] == CH_KEY_U &&
        word_buf[2] == CH_KEY_N) begin
      step_tokens.insert(step_tokens.size(), make_token(K_FUN, 8'h00, 1'b0));
    end else begin
      for (i = 0; i < word_len; i++)
        step_tokens.insert(step_tokens.size(),
                           make_token(K_NAME, word_buf[i], i == word_len - 1));
    end
    if (word_over)
      step_tokens.insert(step_tokens.size(), make_token(K_TOOLONG, 8'h00, 1'b0));
    prev_word = 1'b1;
    word_len  = 0;
    word_over = 1'b0;
  endtask

  // Works out the tokens that one accepted request causes.
  task lex_step(logic [7:0] c, logic eoi);
    token_t     t;
    logic [3:0] kind;
    int         i;
    step_tokens.delete();
    if (text_ended) begin
      step_tokens.insert(step_tokens.size(), make_token(K_AFTEREND, 8'h00, 1'b0));
    end else begin
      if (word_len > 0 && (eoi || !is_word_tail(c))) flush_word();
      if (eoi) begin
        step_tokens.insert(step_tokens.size(), make_token(K_END, 8'h00, 1'b0));
        text_ended = 1'b1;
      end else if (word_len > 0) begin
        // Characters past the buffer are dropped and flagged.
        if (word_len < MAX_WORD) begin
          word_buf[word_len] = c;
          word_len++;
        end else begin
          word_over = 1'b1;
        end
      end else if (c == CH_TAB || c == CH_SPACE) begin
        // Whitespace between tokens is skipped.
      end else if (is_word_head(c)) begin
        word_buf[0] = c;
        word_len    = 1;
        word_over   = 1'b0;
      end else begin
        case (c)
          CH_LPAREN: kind = K_LPAREN;
          CH_RPAREN: kind = K_RPAREN;
          CH_LT:     kind = K_LT;
          CH_GT:     kind = K_GT;
          CH_COLON:  kind = K_COLON;
          CH_COMMA:  kind = K_COMMA;
          default:   kind = K_BADCHAR;
        endcase
        step_tokens.insert(step_tokens.size(), make_token(kind, 8'h00, 1'b0));
        if (kind != K_BADCHAR) prev_word = 1'b0;
      end
    end
    for (i = 0; i < step_tokens.size(); i++) begin
      t = step_tokens[i];
      if (i == step_tokens.size() - 1) t.last = 1'b1;
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endtask

  // Stimulus helpers.
  task push_item(logic [7:0] c, logic eoi);
    char_req_t r;
    r.ch    = c;
    r.eoi   = eoi;
    r.drain = drain_next;
    drain_next = 1'b0;
    char_queue.insert(char_queue.size(), r);
    if (eoi || (c != CH_TAB && c != CH_SPACE)) counted_items++;
  endtask

  task push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_head_char();
    int unsigned r;
    r = $urandom_range(52);
    if (r < 26) return CH_LOWER_A + 8'(r);
    if (r < 52) return CH_UPPER_A + 8'(r - 26);
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] rand_tail_char();
    int unsigned r;
    r = $urandom_range(62);
    if (r < 10) return CH_DIGIT_0 + 8'(r);
    return rand_head_char();
  endfunction

  task push_word(int len);
    int i;
    push_item(rand_head_char(), 1'b0);
    for (i = 1; i < len; i++) push_item(rand_tail_char(), 1'b0);
  endtask

  // Idle rates per phase, taken from how far the sender has got.
  function automatic int sender_idle_pct();
    if (sent_count < total_items / 3) return 33;
    if (sent_count < 2 * total_items / 3) return 54;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent_count < total_items / 3) return 54;
    if (sent_count < 2 * total_items / 3) return 33;
    return 0;
  endfunction

  task report_error(string what, int want, int got);
    error_count++;
    $display("ERROR at token %0d: %s expected %0d got %0d", tokens_checked, what, want, got);
  endtask

  // Sender: offers requests from the queue and feeds accepted ones to the predictor.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        lex_step(s_tdata, s_tuser);
        sent_count++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (char_queue.size() != 0 && !(char_queue[0].drain && expected_tokens.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= char_queue[0].ch;
          s_tuser  <= char_queue[0].eoi;
          void'(char_queue.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with one long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && sent_count >= 3 * total_items / 4) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // Checker: compares each accepted result with the oldest expected token.
  always @(posedge clk) begin
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        report_error("unexpected result, kind", -1, int'(m_tdata[3:0]));
      end else begin
        want = expected_tokens.pop_front();
        if (m_tdata[3:0] !== want.kind)
          report_error("kind", int'(want.kind), int'(m_tdata[3:0]));
        if (m_tdata[11:4] !== want.name_char)
          report_error("name_char", int'(want.name_char), int'(m_tdata[11:4]));
        if (m_tdata[12] !== want.name_last)
          report_error("name_last", int'(want.name_last), int'(m_tdata[12]));
        if (m_tdata[15:13] !== 3'b000) report_error("tdata padding", 0, int'(m_tdata[15:13]));
        if (m_tlast !== want.last) report_error("tlast", int'(want.last), int'(m_tlast));
        if (want.kind == K_FUN) fun_seen++;
        if (want.kind == K_TOOLONG) toolong_seen++;
      end
      tokens_checked++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d tokens outstanding", cycle_count,
               expected_tokens.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned sel;
    int unsigned pick;
    int          i;

    // Directed: keyword, space between words, symbols, whitespace ends, bad bytes.
    push_text("fun fun(");
    push_text("_Az9\t");
    push_item(8'h78, 1'b0);
    push_item(8'hFF, 1'b0);
    push_text("Qz)<>:,");
    push_item(8'h00, 1'b0);

    // Random part, opening with a word that overruns the buffer after a full drain.
    counted_items = 0;
    drain_next = 1'b1;
    push_word(MAX_WORD + 3);
    push_item(CH_SPACE, 1'b0);
    while (counted_items < RANDOM_ITEMS) begin
      if (counted_items >= RANDOM_ITEMS / 2 && counted_items < RANDOM_ITEMS / 2 + 4)
        drain_next = 1'b1;
      sel = $urandom_range(99);
      if (sel < 60) begin
        pick = $urandom_range(99);
        if (pick < 12) push_text("fun");
        else if (pick < 18) begin
          push_text("fun");
          push_item(rand_tail_char(), 1'b0);
        end else if (pick < 88) push_word($urandom_range(6, 1));
        else if (pick < 95) push_word($urandom_range(MAX_WORD - 1, 7));
        else push_word($urandom_range(MAX_WORD + 8, MAX_WORD));
      end else if (sel < 75) begin
        push_item($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
      end else if (sel < 92) begin
        case ($urandom_range(5))
          0: push_item(CH_LPAREN, 1'b0);
          1: push_item(CH_RPAREN, 1'b0);
          2: push_item(CH_LT, 1'b0);
          3: push_item(CH_GT, 1'b0);
          4: push_item(CH_COLON, 1'b0);
          default: push_item(CH_COMMA, 1'b0);
        endcase
      end else begin
        push_item(8'($urandom_range(255)), 1'b0);
      end
    end

    // A pending word flushed by the end mark, then requests after the end.
    push_word($urandom_range(5, 1));
    push_item(8'($urandom_range(255)), 1'b1);
    for (i = 0; i < 4; i++) push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
    total_items = char_queue.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (char_queue.size() != 0 || s_tvalid || expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d checked tokens (%0d keywords, %0d overruns),",
             sent_count, tokens_checked, fun_seen, toolong_seen);
    $display("with both sides stalling, a long output hold-off and drained pauses.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
